// File: hw/rtl/sh2k_pkg.sv
// shared types, constants and round helper functions for the sponge hash unit
`default_nettype none

package sh2k_pkg;

	localparam int StateWords  = 32;
	localparam int RateWords   = 20;
	localparam int DigestWords = 6;
	localparam int RoundsDef   = 20;
	localparam int RoundsMax   = 24;
	localparam int RoundW      = 5;
	localparam int PosW        = 5;
	localparam int OutIdxW     = 3;

	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [7:0] Rcon [RoundsMax] = '{
		8'h24, 8'h3f, 8'h6a, 8'h88, 8'h85, 8'ha3, 8'h08, 8'hd3,
		8'h13, 8'h19, 8'h8a, 8'h2e, 8'h03, 8'h70, 8'h73, 8'h44,
		8'ha4, 8'h09, 8'h38, 8'h22, 8'h29, 8'h9f, 8'h31, 8'hd0
	};

	localparam int Rho [4][4] = '{
		'{0, 14, 20, 22},
		'{0, 13, 68, 91},
		'{0, 27, 42, 106},
		'{0, 32, 48, 80}
	};

	typedef struct packed {
		logic [63:0] data_word;
		logic [6:0]  valid_bits;
		logic        last_item;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic        last_word;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PERM,
		ST_PAD,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic               absorb;
		logic               perm;
		logic [RoundW-1:0]  rnd;
		logic               pad0;
		logic [OutIdxW-1:0] out_idx;
		logic               clear;
	} cmd_t;

	typedef struct packed {
		logic pos_last;
		logic item_full;
	} stat_t;

	typedef logic [127:0] cell_t;
	typedef logic [3:0][127:0] row_t;

	// 4-input bitwise s-box along one row
	function automatic row_t sbox_row(input row_t x);
		row_t o;
		o[3] = (x[3] & x[2]) ^ x[1];
		o[1] = (x[2] | x[1]) ^ x[0];
		o[0] = (o[3] & x[0]) ^ x[3];
		o[2] = (o[1] & x[3]) ^ x[2];
		return o;
	endfunction

	// row multiply shuffle
	function automatic row_t row_mul(input row_t x);
		row_t o;
		o[3] = x[2];
		o[2] = x[1];
		o[1] = x[3] ^ x[0];
		o[0] = x[3];
		return o;
	endfunction

	// right rotation by a constant amount
	function automatic cell_t rotr128(input cell_t v, input int n);
		cell_t r;
		if (n == 0) begin
			r = v;
		end else begin
			r = (v >> n) | (v << (128 - n));
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sh2k_ctrl.sv
// controller: sequences absorb, permutation rounds, padding and digest output
`default_nettype none

module sh2k_ctrl #(
	parameter int ROUNDS = sh2k_pkg::RoundsDef
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_last,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire sh2k_pkg::stat_t stat,
	output sh2k_pkg::cmd_t     cmd
);

	localparam logic [sh2k_pkg::RoundW-1:0]  LastRnd = sh2k_pkg::RoundW'(ROUNDS - 1);
	localparam logic [sh2k_pkg::OutIdxW-1:0] LastOut =
		sh2k_pkg::OutIdxW'(sh2k_pkg::DigestWords - 1);

	sh2k_pkg::ctrl_state_t state_q, state_d;
	logic [sh2k_pkg::RoundW-1:0]  rnd_q;
	logic [sh2k_pkg::OutIdxW-1:0] out_idx_q;
	logic go_pad_q, go_out_q;
	logic accept, out_acc, rnd_done;

	assign accept   = in_valid & ~in_stall;
	assign out_acc  = out_valid & ~out_stall;
	assign rnd_done = (rnd_q == LastRnd);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sh2k_pkg::ST_IDLE: begin
				if (accept && (in_last || stat.pos_last)) begin
					state_d = sh2k_pkg::ST_PERM;
				end
			end
			sh2k_pkg::ST_PERM: begin
				if (rnd_done) begin
					if (go_pad_q) begin
						state_d = sh2k_pkg::ST_PAD;
					end else if (go_out_q) begin
						state_d = sh2k_pkg::ST_OUT;
					end else begin
						state_d = sh2k_pkg::ST_IDLE;
					end
				end
			end
			sh2k_pkg::ST_PAD: begin
				state_d = sh2k_pkg::ST_PERM;
			end
			sh2k_pkg::ST_OUT: begin
				if (out_acc && out_idx_q == LastOut) begin
					state_d = sh2k_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sh2k_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_stall    = (state_q != sh2k_pkg::ST_IDLE);
		out_valid   = (state_q == sh2k_pkg::ST_OUT);
		cmd.absorb  = accept;
		cmd.perm    = (state_q == sh2k_pkg::ST_PERM);
		cmd.rnd     = rnd_q;
		cmd.pad0    = (state_q == sh2k_pkg::ST_PAD);
		cmd.out_idx = out_idx_q;
		cmd.clear   = out_acc && (out_idx_q == LastOut);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sh2k_pkg::ST_IDLE;
			rnd_q     <= '0;
			out_idx_q <= '0;
			go_pad_q  <= 1'b0;
			go_out_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				// full last word closing a block needs one extra permutation
				go_pad_q <= in_last & stat.item_full & stat.pos_last;
				go_out_q <= in_last & ~(stat.item_full & stat.pos_last);
			end else if (state_q == sh2k_pkg::ST_PAD) begin
				go_pad_q <= 1'b0;
				go_out_q <= 1'b1;
			end
			if (state_q == sh2k_pkg::ST_PERM) begin
				rnd_q <= rnd_done ? '0 : rnd_q + 1'b1;
			end
			if (out_acc) begin
				out_idx_q <= (out_idx_q == LastOut) ? '0 : out_idx_q + 1'b1;
			end
		end
	end

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= LastRnd)
		else $error("round counter past last round");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_idx_q <= LastOut)
		else $error("digest index past last word");

	a_last_perm: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> state_q == sh2k_pkg::ST_PERM)
		else $error("last item did not start a permutation");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(go_pad_q && go_out_q))
		else $error("pad and output flags both set");

	a_pad_then_perm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sh2k_pkg::ST_PAD |=> state_q == sh2k_pkg::ST_PERM && rnd_q == '0)
		else $error("padding not followed by a fresh permutation");

endmodule

`default_nettype wire

// File: hw/rtl/sh2k_datapath.sv
// datapath: 2048-bit state, absorb and padding logic, one permutation round per cycle
`default_nettype none

module sh2k_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sh2k_pkg::in_item_t in_data,
	input  wire sh2k_pkg::cmd_t     cmd,
	output sh2k_pkg::stat_t         stat,
	output sh2k_pkg::out_item_t     out_data
);

	localparam logic [sh2k_pkg::PosW-1:0] LastPos = sh2k_pkg::PosW'(sh2k_pkg::RateWords - 1);

	logic [sh2k_pkg::StateWords-1:0][63:0] st_q, perm_w, absorb_mask;
	logic [sh2k_pkg::PosW-1:0] pos_q, pos_nx;
	logic [63:0] pad_w, absorb_w;
	logic [2:0]  nbytes, extra;
	logic        full, pos_last;
	sh2k_pkg::row_t m [4];

	assign nbytes   = in_data.valid_bits[5:3];
	assign extra    = in_data.valid_bits[2:0];
	assign full     = ~in_data.last_item || (in_data.valid_bits >= 7'd64);
	assign pos_last = (pos_q == LastPos);
	assign pos_nx   = pos_q + 1'b1;

	assign stat.pos_last  = pos_last;
	assign stat.item_full = full;

	// partial last word: keep message bytes, trim the partial byte, append the 1 bit
	always_comb begin
		logic [7:0] db;
		pad_w = '0;
		for (int i = 0; i < 8; i++) begin
			db = in_data.data_word[8*i +: 8];
			if (3'(i) < nbytes) begin
				pad_w[8*i +: 8] = db;
			end else if (3'(i) == nbytes) begin
				pad_w[8*i +: 8] = (db & ~(8'hff >> extra)) | (sh2k_pkg::PadByte >> extra);
			end
		end
	end

	assign absorb_w = full ? in_data.data_word : pad_w;

	// words xored into the state on an absorb
	always_comb begin
		absorb_mask = '0;
		absorb_mask[pos_q] = absorb_w;
		// full last word inside a block: pad byte goes to the next rate word
		if (full && in_data.last_item && !pos_last) begin
			absorb_mask[pos_nx] = {56'd0, sh2k_pkg::PadByte};
		end
	end

	// one round of the permutation
	always_comb begin
		sh2k_pkg::cell_t r;
		for (int row = 0; row < 4; row++) begin
			for (int col = 0; col < 4; col++) begin
				m[row][col] = {st_q[(col*4+row)*2+1], st_q[(col*4+row)*2]};
			end
		end
		for (int row = 0; row < 4; row++) begin
			m[row] = sh2k_pkg::sbox_row(m[row]);
		end
		m[2] = m[2] ^ m[3];
		m[0] = m[0] ^ m[1];
		m[1] = sh2k_pkg::row_mul(m[1]);
		m[3] = sh2k_pkg::row_mul(m[3]);
		m[1] = m[1] ^ m[2];
		m[3] = m[3] ^ m[0];
		m[0] = sh2k_pkg::row_mul(sh2k_pkg::row_mul(m[0]));
		m[2] = sh2k_pkg::row_mul(sh2k_pkg::row_mul(m[2]));
		m[2] = m[2] ^ m[3];
		m[0] = m[0] ^ m[1];
		m[1] = m[1] ^ m[2];
		m[3] = m[3] ^ m[0];
		// rho set picked by round mod 4
		for (int row = 1; row < 4; row++) begin
			for (int col = 0; col < 4; col++) begin
				r = m[row][col];
				for (int k = 0; k < 4; k++) begin
					if (cmd.rnd[1:0] == 2'(k)) begin
						r = sh2k_pkg::rotr128(m[row][col], sh2k_pkg::Rho[k][row]);
					end
				end
				m[row][col] = r;
			end
		end
		m[3][3][7:0] = m[3][3][7:0] ^ sh2k_pkg::Rcon[cmd.rnd];
		for (int row = 0; row < 4; row++) begin
			for (int col = 0; col < 4; col++) begin
				perm_w[(col*4+row)*2]   = m[row][col][63:0];
				perm_w[(col*4+row)*2+1] = m[row][col][127:64];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			pos_q <= '0;
		end else if (cmd.clear) begin
			st_q  <= '0;
			pos_q <= '0;
		end else if (cmd.absorb) begin
			st_q <= st_q ^ absorb_mask;
			if (full) begin
				pos_q <= pos_last ? '0 : pos_nx;
			end
		end else if (cmd.perm) begin
			st_q <= perm_w;
		end else if (cmd.pad0) begin
			st_q[0][7:0] <= st_q[0][7:0] ^ sh2k_pkg::PadByte;
		end
	end

	assign out_data.digest_word = st_q[{2'b00, cmd.out_idx}];
	assign out_data.last_word   = (cmd.out_idx == sh2k_pkg::OutIdxW'(sh2k_pkg::DigestWords - 1));

endmodule

`default_nettype wire

// File: hw/rtl/sponge_hash_2048bit_state_unit.sv
// top level of the sponge hash unit with a 2048-bit state and 48-byte digest
// a word that closes no block is only absorbed; one that closes a block is then permuted
// last item: first digest item after its permutation, or after permutation, pad step and
// a second permutation for a full last word that closes a block; then six digest items,
// one per cycle without out_stall; new input is taken only in the idle state (in_stall)
// reset: arst_n clears the state and word position to zero; no clearing pass
`default_nettype none

module sponge_hash_2048bit_state_unit #(
	parameter int ROUNDS = sh2k_pkg::RoundsDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input item channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sh2k_pkg::in_item_t  in_data,
	// digest item channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sh2k_pkg::out_item_t      out_data
);

	// command and status between controller and datapath
	sh2k_pkg::cmd_t  cmd;
	sh2k_pkg::stat_t stat;

	// controller: idle / permute / pad / digest out sequencing
	sh2k_ctrl #(
		.ROUNDS(ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.last_item),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: state register, absorb and padding, round logic, digest select
	sh2k_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (cmd),
		.stat    (stat),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

// File: dv/sh2k_digest_checker.sv
// digest checker for the sponge hash unit: predicts every digest item and compares
`default_nettype none

module sh2k_digest_checker #(
	parameter int ROUNDS = sh2k_pkg::RoundsDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire sh2k_pkg::in_item_t  in_data,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire sh2k_pkg::out_item_t out_data,
	output int                       mismatches,
	output int                       waiting,
	output int                       digests_seen
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [127:0] lane128_t;
	typedef logic [3:0][127:0] lane_row_t;

	localparam int unsigned BlockWords = 20;
	localparam int unsigned OutWords   = 6;

	// round keys, entry 0 in the low byte
	localparam logic [24*8-1:0] RoundKeys = {
		8'hd0, 8'h31, 8'h9f, 8'h29, 8'h22, 8'h38, 8'h09, 8'ha4,
		8'h44, 8'h73, 8'h70, 8'h03, 8'h2e, 8'h8a, 8'h19, 8'h13,
		8'hd3, 8'h08, 8'ha3, 8'h85, 8'h88, 8'h6a, 8'h3f, 8'h24
	};

	logic [63:0]            lanes [32];
	int unsigned            rate_pos;
	sh2k_pkg::out_item_t    digest_q [$];

	function automatic int unsigned rot_amount(input int unsigned sel, input int unsigned row);
		logic [3:0][6:0] amts;
		case (sel)
			0: amts = {7'd22, 7'd20, 7'd14, 7'd0};
			1: amts = {7'd91, 7'd68, 7'd13, 7'd0};
			2: amts = {7'd106, 7'd42, 7'd27, 7'd0};
			default: amts = {7'd80, 7'd48, 7'd32, 7'd0};
		endcase
		return amts[row];
	endfunction

	function automatic lane128_t lane_ror(input lane128_t v, input int unsigned n);
		logic [255:0] w;
		w = {v, v} >> n;
		return w[127:0];
	endfunction

	function automatic lane_row_t row_shuffle(input lane_row_t x);
		return {x[2], x[1], x[3] ^ x[0], x[3]};
	endfunction

	function automatic void clear_sponge();
		foreach (lanes[i]) lanes[i] = '0;
		rate_pos = 0;
	endfunction

	function automatic void xor_into_rate(input logic [63:0] w);
		if (rate_pos >= BlockWords) rate_pos = 0;
		lanes[rate_pos] ^= w;
	endfunction

	function automatic void permute_sponge();
		lane_row_t m [4];
		lane_row_t x;
		lane128_t  t0, t1, t2, t3;
		for (int row = 0; row < 4; row++)
			for (int col = 0; col < 4; col++)
				m[row][col] = {lanes[(col*4+row)*2+1], lanes[(col*4+row)*2]};
		for (int r = 0; r < ROUNDS; r++) begin
			for (int row = 0; row < 4; row++) begin
				x = m[row];
				t3 = (x[3] & x[2]) ^ x[1];
				t1 = (x[2] | x[1]) ^ x[0];
				t0 = (t3 & x[0]) ^ x[3];
				t2 = (t1 & x[3]) ^ x[2];
				m[row] = {t3, t2, t1, t0};
			end
			m[2] ^= m[3];
			m[0] ^= m[1];
			m[1] = row_shuffle(m[1]);
			m[3] = row_shuffle(m[3]);
			m[1] ^= m[2];
			m[3] ^= m[0];
			m[0] = row_shuffle(row_shuffle(m[0]));
			m[2] = row_shuffle(row_shuffle(m[2]));
			m[2] ^= m[3];
			m[0] ^= m[1];
			m[1] ^= m[2];
			m[3] ^= m[0];
			for (int row = 1; row < 4; row++)
				for (int col = 0; col < 4; col++)
					m[row][col] = lane_ror(m[row][col], rot_amount(r % 4, row));
			m[3][3][7:0] ^= RoundKeys[8*(r%24) +: 8];
		end
		for (int row = 0; row < 4; row++)
			for (int col = 0; col < 4; col++)
				{lanes[(col*4+row)*2+1], lanes[(col*4+row)*2]} = m[row][col];
	endfunction

	// absorb one word and permute on a full block; on a last word pad, permute, queue the digest and clear
	function automatic void absorb_item(input sh2k_pkg::in_item_t it);
		logic [63:0] d, keep, pb;
		int unsigned nbits, nbytes, spare;
		sh2k_pkg::out_item_t dw;
		d = it.data_word;
		nbits = it.valid_bits;
		if (nbits > 64 || !it.last_item) nbits = 64;
		if (nbits == 64) begin
			xor_into_rate(d);
			rate_pos++;
			if (rate_pos >= BlockWords) begin
				permute_sponge();
				rate_pos = 0;
			end
			if (!it.last_item) return;
			xor_into_rate(64'h80);
		end else begin
			nbytes = nbits >> 3;
			spare = nbits & 7;
			keep = (nbytes == 0) ? 64'd0 : ((64'd1 << (8*nbytes)) - 64'd1);
			if (spare != 0)
				pb = ((d >> (8*nbytes)) & 64'hff & ((64'hff << (8 - spare)) & 64'hff))
					| (64'h80 >> spare);
			else
				pb = 64'h80;
			xor_into_rate((d & keep) | (pb << (8*nbytes)));
		end
		permute_sponge();
		for (int k = 0; k < OutWords; k++) begin
			dw.digest_word = lanes[k];
			dw.last_word = (k == OutWords - 1);
			digest_q.push_back(dw);
		end
		clear_sponge();
	endfunction

	initial begin
		mismatches = 0;
		waiting = 0;
		digests_seen = 0;
		clear_sponge();
	end

	always @(posedge clk or negedge arst_n) begin
		sh2k_pkg::out_item_t exp_w;
		if (!arst_n) begin
			clear_sponge();
			digest_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				digests_seen++;
				if (digest_q.size() == 0) begin
					$error("digest item with nothing expected: %h", out_data);
					mismatches++;
				end else begin
					exp_w = digest_q.pop_front();
					if (out_data.digest_word !== exp_w.digest_word) begin
						$error("digest_word: expected %h, actual %h",
							exp_w.digest_word, out_data.digest_word);
						mismatches++;
					end
					if (out_data.last_word !== exp_w.last_word) begin
						$error("last_word: expected %b, actual %b",
							exp_w.last_word, out_data.last_word);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) absorb_item(in_data);
		end
		waiting = digest_q.size();
	end

endmodule

`default_nettype wire

// File: dv/tb.sv
// testbench top for the sponge hash unit: stimulus, idling, hold-off and verdict
`default_nettype none

module tb;

	timeunit 1ns;
	timeprecision 1ps;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                out_stall = 1'b0;
	sh2k_pkg::in_item_t  in_data = '0;
	logic                in_stall;
	logic                out_valid;
	sh2k_pkg::out_item_t out_data;

	int mismatches;
	int waiting;
	int digests_seen;

	// idling knobs, in percent of cycles
	int send_idle_pct = 0;
	int stall_pct = 0;

	// long hold-off of the digest side, counted in the receiver process
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	int items_sent = 0;
	int msgs_sent = 0;

	always #5 clk = ~clk;

	sponge_hash_2048bit_state_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	sh2k_digest_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.mismatches   (mismatches),
		.waiting      (waiting),
		.digests_seen (digests_seen)
	);

	// digest side: random stall, or a long hold-off once requested
	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// offer one item; entered and left just after a falling edge
	// valid stays high straight into the next item unless a gap is drawn
	task automatic send_item(input sh2k_pkg::in_item_t it);
		int gaps;
		gaps = 0;
		while ($urandom_range(99) < send_idle_pct && gaps < 60) gaps++;
		if (gaps > 0) begin
			in_valid <= 1'b0;
			repeat (gaps) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_one(input logic [63:0] d, input logic [6:0] nbits, input logic fin);
		sh2k_pkg::in_item_t it;
		it.data_word = d;
		it.valid_bits = nbits;
		it.last_item = fin;
		send_item(it);
		if (fin) msgs_sent++;
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// message lengths lean on the block boundary: 19, 20, 21 and 39, 40, 41 words
	function automatic int pick_len();
		int k;
		k = $urandom_range(9);
		if (k < 4) return $urandom_range(6, 1);
		if (k < 7) return 20 * $urandom_range(2, 1) + $urandom_range(2) - 1;
		return $urandom_range(45, 1);
	endfunction

	// bit count of the closing word: full, partial, or any value up to 127
	function automatic logic [6:0] pick_tail_bits();
		int k;
		k = $urandom_range(9);
		if (k < 4) return 7'd64;
		if (k < 8) return 7'($urandom_range(63));
		return 7'($urandom_range(127));
	endfunction

	task automatic send_message(input int nwords, input logic [6:0] tail_bits);
		logic [6:0] nb;
		for (int i = 0; i < nwords; i++) begin
			if (i == nwords - 1) begin
				send_one(rand_word(), tail_bits, 1'b1);
			end else begin
				// a partial count on a word that is not last is ignored by the block
				nb = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'd64;
				send_one(rand_word(), nb, 1'b0);
			end
		end
	endtask

	task automatic random_phase(input int idle_pct, input int stl_pct, input bit with_hold);
		int target;
		int len;
		send_idle_pct = idle_pct;
		stall_pct = stl_pct;
		if (with_hold) hold_req = 1'b1;
		target = items_sent + 77;
		while (items_sent < target) begin
			// last message of the phase is cut to fit the item budget
			len = pick_len();
			if (len > target - items_sent) len = target - items_sent;
			send_message(len, pick_tail_bits());
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty message, full and partial closing words, bit counts past 64
		send_one(64'd0, 7'd0, 1'b1);
		send_one('1, 7'd64, 1'b1);
		send_one('1, 7'd1, 1'b1);
		send_one('1, 7'd7, 1'b1);
		send_one(64'h0123456789abcdef, 7'd8, 1'b1);
		send_one('1, 7'd63, 1'b1);
		send_one(rand_word(), 7'd127, 1'b1);
		send_one(rand_word(), 7'd65, 1'b1);
		// partial counts on words that are not last
		send_one(rand_word(), 7'd0, 1'b0);
		send_one(rand_word(), 7'd37, 1'b0);
		send_one('1, 7'd12, 1'b1);
		// all-zero data
		send_one(64'd0, 7'd64, 1'b0);
		send_one(64'd0, 7'd64, 1'b1);

		// random: free running with one long hold-off, then sender gaps,
		// then receiver stalls, then both
		random_phase(0, 0, 1'b1);
		random_phase(88, 0, 1'b0);
		random_phase(0, 88, 1'b0);
		random_phase(29, 29, 1'b0);
		in_valid <= 1'b0;

		// drain, then allow a block-closing last item worth of cycles
		wait (waiting == 0);
		repeat (60) @(posedge clk);

		$display("run covered %0d items in %0d messages and %0d digest words",
			items_sent, msgs_sent, digests_seen);
		$display("phases: free running with a 300-cycle hold-off, sender gaps, stalls, both");
		if (mismatches == 0 && waiting == 0) begin
			$display("sponge_hash_2048bit_state_unit: match");
		end else begin
			$display("sponge_hash_2048bit_state_unit: mismatch");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(5_000_000);
		$display("sponge_hash_2048bit_state_unit: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
